@@ rtl/grid_cell_mean_classifier_macros.svh @@
// ----------------------------------------------------------------------------
// Grid cell mean classifier assertion macros
// Concurrent check wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef GRID_CELL_MEAN_CLASSIFIER_MACROS_SVH
`define GRID_CELL_MEAN_CLASSIFIER_MACROS_SVH

`ifndef SYNTHESIS
`define GCMC_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("grid_cell_mean_classifier: check failed");
`define GCMC_NEVER(name, clk, rstn, expr) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("grid_cell_mean_classifier: forbidden condition");
`else
`define GCMC_ASSERT(name, clk, rstn, prop)
`define GCMC_NEVER(name, clk, rstn, expr)
`endif

`endif

@@ rtl/gcmc_pkg.sv @@
// ----------------------------------------------------------------------------
// Grid cell mean classifier package
// Widths, codes and the item types shared by the classifier modules.
// ----------------------------------------------------------------------------
`default_nettype none

package gcmc_pkg;

  localparam int unsigned COL_W          = 10;
  localparam int unsigned FS_W           = 11;
  localparam int unsigned CS_W           = 7;
  localparam int unsigned CNT_W          = 7;
  localparam int unsigned OFS_W          = 6;
  localparam int unsigned CELL_W         = 6;
  localparam int unsigned SUM_W          = 20;
  localparam int unsigned LIM_W          = 22;
  localparam int unsigned CNTPIX_W       = 14;
  localparam int unsigned PROD_W         = 22;
  localparam int unsigned GRAY_W         = 8;
  localparam int unsigned IDX_W          = 3;
  localparam int unsigned CFG_W          = 11;
  localparam int unsigned DIV_STEPS      = 10;
  localparam int unsigned CELL_SIDE_MAX  = 64;
  localparam int unsigned FRAME_SIDE_MAX = 1024;

  localparam int unsigned GRAY_R     = 4899;
  localparam int unsigned GRAY_G     = 9617;
  localparam int unsigned GRAY_B     = 1868;
  localparam int unsigned GRAY_RND   = 8192;
  localparam int unsigned GRAY_SHIFT = 14;

  typedef enum logic [IDX_W-1:0] {
    CFG_FRAME_SIDE  = 3'd0,
    CFG_CELLS       = 3'd1,
    CFG_CELL_SIDE   = 3'd2,
    CFG_MARGIN      = 3'd3,
    CFG_DARK_LIMIT  = 3'd4,
    CFG_LIGHT_LIMIT = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PIECE_EMPTY = 2'd0,
    PIECE_DARK  = 2'd1,
    PIECE_LIGHT = 2'd2
  } piece_e;

  typedef struct packed {
    logic              valid;
    logic              win;
    logic              first;
    logic              emit;
    logic              force0;
    logic              done;
    logic [CELL_W-1:0] cx;
    logic [3:0]        cy;
    logic [GRAY_W-1:0] gray;
    logic [SUM_W-1:0]  sum;
  } tok_t;

  typedef struct packed {
    logic [FS_W-1:0] fs;
    logic [CS_W-1:0] cs;
    logic [CS_W-1:0] cs_m1;
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] n_m1;
    logic [CS_W-1:0] lo;
    logic [CS_W-1:0] hi;
    logic            have_win;
    logic            grid_ok;
  } geom_t;

  typedef struct packed {
    logic             load;
    logic [COL_W-1:0] quo_col;
    logic [CS_W-1:0]  rem_col;
    logic [COL_W-1:0] quo_row;
    logic [CS_W-1:0]  rem_row;
  } divres_t;

endpackage

`default_nettype wire

@@ rtl/gcmc_div.sv @@
// ----------------------------------------------------------------------------
// Position realign divider
// Splits the pixel column and row into cell index and offset, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gcmc_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [gcmc_pkg::COL_W-1:0] col_i,
  input  logic [gcmc_pkg::COL_W-1:0] row_i,
  input  logic [gcmc_pkg::CS_W-1:0]  divisor_i,
  output logic                    busy_o,
  output gcmc_pkg::divres_t       res_o
);
  import gcmc_pkg::*;

  localparam int unsigned STEP_W = $clog2(DIV_STEPS);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [COL_W-1:0]  a_q, b_q;
  logic [CS_W-1:0]   ra_q, rb_q;
  logic [CS_W:0]     ra_t, rb_t, dv;
  logic              ge_a, ge_b;
  logic [CS_W-1:0]   ra_d, rb_d;

  always_comb begin
    dv   = {1'b0, divisor_i};
    ra_t = {ra_q, a_q[COL_W-1]};
    rb_t = {rb_q, b_q[COL_W-1]};
    ge_a = ra_t >= dv;
    ge_b = rb_t >= dv;
    ra_d = ge_a ? CS_W'(ra_t - dv) : ra_t[CS_W-1:0];
    rb_d = ge_b ? CS_W'(rb_t - dv) : rb_t[CS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= STEP_W'(DIV_STEPS - 1);
    end else if (busy_q) begin
      if (step_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        step_q <= step_q - STEP_W'(1);
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= col_i;
      b_q  <= row_i;
      ra_q <= '0;
      rb_q <= '0;
    end else if (busy_q) begin
      a_q  <= {a_q[COL_W-2:0], ge_a};
      b_q  <= {b_q[COL_W-2:0], ge_b};
      ra_q <= ra_d;
      rb_q <= rb_d;
    end
  end

  assign busy_o          = busy_q | done_q;
  assign res_o.load      = done_q;
  assign res_o.quo_col   = a_q;
  assign res_o.rem_col   = ra_q;
  assign res_o.quo_row   = b_q;
  assign res_o.rem_row   = rb_q;

endmodule

`default_nettype wire

@@ rtl/gcmc_cell.sv @@
// ----------------------------------------------------------------------------
// Classifier chain cell
// Holds the window sum of one grid column and passes each item on.
// ----------------------------------------------------------------------------
`default_nettype none

module gcmc_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  gcmc_pkg::tok_t tok_i,
  output gcmc_pkg::tok_t tok_o
);
  import gcmc_pkg::*;

  logic [SUM_W-1:0] sum_q, sum_d;
  logic             hit;
  logic             valid_q;
  tok_t             pl_q, pl_d;

  always_comb begin
    hit   = tok_i.valid && tok_i.win && (tok_i.cx == CELL_W'(IDX));
    sum_d = tok_i.first ? SUM_W'(tok_i.gray) : sum_q + SUM_W'(tok_i.gray);
    pl_d  = tok_i;
    if (hit) begin
      pl_d.sum = sum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= tok_i.valid;
      if (hit) begin
        sum_q <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pl_q <= pl_d;
    end
  end

  always_comb begin
    tok_o       = pl_q;
    tok_o.valid = valid_q;
  end

endmodule

`default_nettype wire

@@ rtl/gcmc_front.sv @@
// ----------------------------------------------------------------------------
// Classifier front end
// Tracks raster position, decodes window flags and converts pixels to gray.
// ----------------------------------------------------------------------------
`default_nettype none

module gcmc_front #(
  parameter int unsigned MAX_CELLS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic                       accept_i,
  input  logic [7:0]                 blue_i,
  input  logic [7:0]                 green_i,
  input  logic [7:0]                 red_i,
  input  logic                       frame_start_i,
  input  gcmc_pkg::geom_t            geom_i,
  input  gcmc_pkg::divres_t          div_i,
  output logic [gcmc_pkg::COL_W-1:0] col_o,
  output logic [gcmc_pkg::COL_W-1:0] row_o,
  output gcmc_pkg::tok_t             tok_o
);
  import gcmc_pkg::*;

  logic [COL_W-1:0] col_q, row_q, col_d, row_d;
  logic [OFS_W-1:0] ox_q, oy_q, ox_d, oy_d;
  logic [CNT_W-1:0] cx_q, cy_q, cx_d, cy_d;

  logic [COL_W-1:0] p_col, p_row;
  logic [OFS_W-1:0] p_ox, p_oy;
  logic [CNT_W-1:0] p_cx, p_cy, cx_inc, cy_inc;
  logic [CS_W-1:0]  oxe, oye;
  logic [FS_W-1:0]  nxt_col, nxt_row;
  logic             in_grid, in_win, first, emit, done;
  logic             col_wrap, row_wrap, ox_end, oy_end;
  logic             load_cx_sat, load_cy_sat;

  logic                s1_valid_q, s2_valid_q;
  tok_t                s1_q, s2_q, s1_d, s2_d;
  logic [PROD_W-1:0]   pr_q, pg_q, pb_q, gsum;

  always_comb begin
    p_col = frame_start_i ? '0 : col_q;
    p_row = frame_start_i ? '0 : row_q;
    p_ox  = frame_start_i ? '0 : ox_q;
    p_oy  = frame_start_i ? '0 : oy_q;
    p_cx  = frame_start_i ? '0 : cx_q;
    p_cy  = frame_start_i ? '0 : cy_q;
    oxe   = {1'b0, p_ox};
    oye   = {1'b0, p_oy};

    in_grid = geom_i.grid_ok && (p_cx < geom_i.n) && (p_cy < geom_i.n);
    in_win  = geom_i.have_win && (oxe >= geom_i.lo) && (oxe <= geom_i.hi) &&
              (oye >= geom_i.lo) && (oye <= geom_i.hi);
    first   = (oxe == geom_i.lo) && (oye == geom_i.lo);
    emit    = geom_i.have_win ?
              (in_win && (oxe == geom_i.hi) && (oye == geom_i.hi)) :
              ((oxe == geom_i.cs_m1) && (oye == geom_i.cs_m1));
    done    = (p_cx == geom_i.n_m1) && (p_cy == geom_i.n_m1);

    nxt_col  = {1'b0, p_col} + FS_W'(1);
    nxt_row  = {1'b0, p_row} + FS_W'(1);
    col_wrap = nxt_col >= geom_i.fs;
    row_wrap = nxt_row >= geom_i.fs;
    ox_end   = (oxe + CS_W'(1)) == geom_i.cs;
    oy_end   = (oye + CS_W'(1)) == geom_i.cs;
    cx_inc   = (p_cx >= CNT_W'(MAX_CELLS)) ? p_cx : p_cx + CNT_W'(1);
    cy_inc   = (p_cy >= CNT_W'(MAX_CELLS)) ? p_cy : p_cy + CNT_W'(1);

    col_d = p_col;
    row_d = p_row;
    ox_d  = p_ox;
    oy_d  = p_oy;
    cx_d  = p_cx;
    cy_d  = p_cy;
    if (col_wrap) begin
      col_d = '0;
      ox_d  = '0;
      cx_d  = '0;
      if (row_wrap) begin
        row_d = '0;
        oy_d  = '0;
        cy_d  = '0;
      end else begin
        row_d = nxt_row[COL_W-1:0];
        oy_d  = oy_end ? '0 : p_oy + OFS_W'(1);
        cy_d  = oy_end ? cy_inc : p_cy;
      end
    end else begin
      col_d = nxt_col[COL_W-1:0];
      ox_d  = ox_end ? '0 : p_ox + OFS_W'(1);
      cx_d  = ox_end ? cx_inc : p_cx;
    end

    load_cx_sat = div_i.quo_col > COL_W'(MAX_CELLS);
    load_cy_sat = div_i.quo_row > COL_W'(MAX_CELLS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      ox_q  <= '0;
      oy_q  <= '0;
      cx_q  <= '0;
      cy_q  <= '0;
    end else if (div_i.load) begin
      ox_q <= div_i.rem_col[OFS_W-1:0];
      oy_q <= div_i.rem_row[OFS_W-1:0];
      cx_q <= load_cx_sat ? CNT_W'(MAX_CELLS) : div_i.quo_col[CNT_W-1:0];
      cy_q <= load_cy_sat ? CNT_W'(MAX_CELLS) : div_i.quo_row[CNT_W-1:0];
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
      ox_q  <= ox_d;
      oy_q  <= oy_d;
      cx_q  <= cx_d;
      cy_q  <= cy_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= accept_i && in_grid;
      s2_valid_q <= s1_valid_q;
    end
  end

  assign gsum = pr_q + pg_q + pb_q + PROD_W'(GRAY_RND);

  always_comb begin
    s1_d        = '0;
    s1_d.valid  = 1'b1;
    s1_d.win    = in_win;
    s1_d.first  = first;
    s1_d.emit   = emit;
    s1_d.force0 = !geom_i.have_win;
    s1_d.done   = done;
    s1_d.cx     = p_cx[CELL_W-1:0];
    s1_d.cy     = p_cy[3:0];
    s2_d        = s1_q;
    s2_d.gray   = gsum[GRAY_SHIFT +: GRAY_W];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_q <= s1_d;
      pr_q <= PROD_W'(red_i) * PROD_W'(GRAY_R);
      pg_q <= PROD_W'(green_i) * PROD_W'(GRAY_G);
      pb_q <= PROD_W'(blue_i) * PROD_W'(GRAY_B);
      s2_q <= s2_d;
    end
  end

  always_comb begin
    tok_o       = s2_q;
    tok_o.valid = s2_valid_q;
  end

  assign col_o = col_q;
  assign row_o = row_q;

endmodule

`default_nettype wire

@@ rtl/grid_cell_mean_classifier.sv @@
// ----------------------------------------------------------------------------
// Grid cell mean classifier
// Sums gray levels in the inner window of each grid cell and classifies it.
// ----------------------------------------------------------------------------
// Takes one pixel per clock. Each pixel goes through two front stages (gray
// products, gray sum), then a row of MAX_CELLS cells that each keep the window
// sum of one grid column, then an output register. A stall on the output side
// freezes the whole pipeline. After reset and after every register write the
// input is held off while a bit-serial divider maps the current raster position
// onto the new cell size.
`default_nettype none

`include "grid_cell_mean_classifier_macros.svh"

module grid_cell_mean_classifier #(
  parameter int unsigned MAX_CELLS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [23:0]                 s_axis_tdata,  // blue, green, red
  input  logic                        s_axis_tuser,  // frame_start
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [15:0]                 m_axis_tdata,  // cell_row, cell_col, piece, zero pad
  output logic                        m_axis_tlast,  // frame_done
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [gcmc_pkg::IDX_W-1:0]  cfg_index_i,
  input  logic [gcmc_pkg::CFG_W-1:0]  cfg_data_i
);
  import gcmc_pkg::*;

  logic [10:0] frame_side_q;
  logic [4:0]  cells_q;
  logic [6:0]  cell_side_q;
  logic [4:0]  margin_q;
  logic [7:0]  dark_q, light_q;
  logic        cfg_fire, pend_q;

  geom_t                geom_q, geom_d;
  logic [CS_W-1:0]      side_q, two_m;
  logic [CNTPIX_W-1:0]  count_q;
  logic [LIM_W-1:0]     dark_cnt_q, light_cnt_q;

  logic              adv, busy, accept, div_busy;
  divres_t           div_res;
  logic [COL_W-1:0]  col, row;
  tok_t              chain [MAX_CELLS+1];
  tok_t              tail;
  logic [LIM_W-1:0]  tail_sum;
  piece_e            piece_d;

  logic              m_valid_q;
  logic [3:0]        out_row_q, out_col_q;
  piece_e            out_piece_q;
  logic              out_done_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_side_q <= 11'd480;
      cells_q      <= 5'd12;
      cell_side_q  <= 7'd40;
      margin_q     <= 5'd5;
      dark_q       <= 8'd90;
      light_q      <= 8'd230;
      pend_q       <= 1'b1;
    end else begin
      pend_q <= cfg_fire;
      if (cfg_fire) begin
        case (cfg_index_i)
          CFG_FRAME_SIDE:  frame_side_q <= cfg_data_i[10:0];
          CFG_CELLS:       cells_q      <= cfg_data_i[4:0];
          CFG_CELL_SIDE:   cell_side_q  <= cfg_data_i[6:0];
          CFG_MARGIN:      margin_q     <= cfg_data_i[4:0];
          CFG_DARK_LIMIT:  dark_q       <= cfg_data_i[7:0];
          CFG_LIGHT_LIMIT: light_q      <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    geom_d.fs = (frame_side_q == '0) ? FS_W'(1) :
                (frame_side_q > FS_W'(FRAME_SIDE_MAX)) ? FS_W'(FRAME_SIDE_MAX) :
                frame_side_q;
    geom_d.cs = (cell_side_q > CS_W'(CELL_SIDE_MAX)) ? CS_W'(CELL_SIDE_MAX) : cell_side_q;
    geom_d.n  = ({2'b00, cells_q} > CNT_W'(MAX_CELLS)) ? CNT_W'(MAX_CELLS) :
                {2'b00, cells_q};
    geom_d.cs_m1    = geom_d.cs - CS_W'(1);
    geom_d.n_m1     = geom_d.n - CNT_W'(1);
    geom_d.lo       = {2'b00, margin_q};
    two_m           = {1'b0, margin_q, 1'b0};
    geom_d.hi       = geom_d.cs - CS_W'(1) - geom_d.lo;
    geom_d.have_win = two_m < geom_d.cs;
    geom_d.grid_ok  = (geom_d.cs != '0) && (geom_d.n != '0);
  end

  always_ff @(posedge clk_i) begin
    geom_q      <= geom_d;
    side_q      <= geom_d.cs - two_m;
    count_q     <= CNTPIX_W'(side_q) * CNTPIX_W'(side_q);
    dark_cnt_q  <= LIM_W'(dark_q) * LIM_W'(count_q);
    light_cnt_q <= LIM_W'(light_q) * LIM_W'(count_q);
  end

  gcmc_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (pend_q),
    .col_i     (col),
    .row_i     (row),
    .divisor_i (geom_q.cs),
    .busy_o    (div_busy),
    .res_o     (div_res)
  );

  assign busy          = pend_q | div_busy;
  assign adv           = !m_valid_q || m_axis_tready;
  assign s_axis_tready = adv && !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  gcmc_front #(
    .MAX_CELLS (MAX_CELLS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .accept_i      (accept),
    .blue_i        (s_axis_tdata[7:0]),
    .green_i       (s_axis_tdata[15:8]),
    .red_i         (s_axis_tdata[23:16]),
    .frame_start_i (s_axis_tuser),
    .geom_i        (geom_q),
    .div_i         (div_res),
    .col_o         (col),
    .row_o         (row),
    .tok_o         (chain[0])
  );

  for (genvar i = 0; i < MAX_CELLS; i++) begin : g_cell
    gcmc_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .tok_i  (chain[i]),
      .tok_o  (chain[i+1])
    );
  end

  assign tail     = chain[MAX_CELLS];
  assign tail_sum = LIM_W'(tail.sum);

  always_comb begin
    piece_d = PIECE_EMPTY;
    if (!tail.force0) begin
      if (tail_sum < dark_cnt_q) begin
        piece_d = PIECE_DARK;
      end else if (tail_sum > light_cnt_q) begin
        piece_d = PIECE_LIGHT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= tail.valid && tail.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_row_q   <= tail.cy;
      out_col_q   <= tail.cx[3:0];
      out_piece_q <= piece_d;
      out_done_q  <= tail.done;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'b000000, out_piece_q, out_col_q, out_row_q};
  assign m_axis_tlast  = out_done_q;

  `GCMC_ASSERT(a_cfg_holds_input, clk_i, rst_ni, cfg_fire |=> !s_axis_tready)
  `GCMC_NEVER(a_load_vs_accept, clk_i, rst_ni, div_res.load && accept)
  `GCMC_NEVER(a_piece_code, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata[9:8] == 2'b11))

endmodule

`default_nettype wire

@@ tb/sv/tb_grid_cell_mean_classifier.sv @@
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// Grid cell mean classifier testbench
// Streams BGR pixels over many small grid setups, including out-of-range,
// empty-window and oversized-grid settings. An in-bench model predicts the
// verdict of each cell, and every result item is checked in order while both
// stream sides idle and stall at random.
// ----------------------------------------------------------------------------

module tb_grid_cell_mean_classifier;
  import gcmc_pkg::*;

  localparam int unsigned MAX_CELLS       = 16;
  localparam int unsigned RESULT_LATENCY  = MAX_CELLS + 3;
  localparam int unsigned SETTLE_CYCLES   = 2 * RESULT_LATENCY;
  localparam int unsigned WATCHDOG_CYCLES = 2000;
  localparam int unsigned RANDOM_ITEMS    = 1200;
  localparam logic [IDX_W-1:0] SPARE_REG_IDX = 3'd7;

  typedef enum {TEX_NOISE, TEX_GRAY, TEX_TONES, TEX_FLAT} texture_e;
  typedef enum {DRAIN_FREE, DRAIN_COIN, DRAIN_BURSTY, DRAIN_HICCUP} drain_e;

  class cell_verdict_board;
    typedef struct {
      logic [3:0] row;
      logic [3:0] col;
      piece_e     piece;
      logic       done;
    } verdict_t;

    int unsigned frame_side, cells, cell_side, margin, dark_limit, light_limit;
    bit [9:0]    col, row;
    int unsigned window_sums [MAX_CELLS];
    verdict_t    verdicts_q [$];
    int unsigned failures;

    function new();
      frame_side  = 480;
      cells       = 12;
      cell_side   = 40;
      margin      = 5;
      dark_limit  = 90;
      light_limit = 230;
      col         = '0;
      row         = '0;
      failures    = 0;
      foreach (window_sums[i]) window_sums[i] = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] index, logic [CFG_W-1:0] data);
      case (index)
        CFG_FRAME_SIDE:  frame_side  = data[10:0];
        CFG_CELLS:       cells       = data[4:0];
        CFG_CELL_SIDE:   cell_side   = data[6:0];
        CFG_MARGIN:      margin      = data[4:0];
        CFG_DARK_LIMIT:  dark_limit  = data[7:0];
        CFG_LIGHT_LIMIT: light_limit = data[7:0];
        default: ;
      endcase
    endfunction

    function void note_pixel(int unsigned blue, green, red, bit start);
      int unsigned gray, fs, n, cs, c, r, cx, cy, ox, oy, lo, hi, count;
      bit          last;
      verdict_t    v;
      gray = (red * GRAY_R + green * GRAY_G + blue * GRAY_B + GRAY_RND) >> GRAY_SHIFT;
      fs = (frame_side == 0) ? 1 : (frame_side > FRAME_SIDE_MAX) ? FRAME_SIDE_MAX : frame_side;
      n  = (cells > MAX_CELLS) ? MAX_CELLS : cells;
      cs = (cell_side > CELL_SIDE_MAX) ? CELL_SIDE_MAX : cell_side;
      last    = 1'b0;
      v.piece = PIECE_EMPTY;
      if (start) begin
        col = '0;
        row = '0;
      end
      c = col;
      r = row;
      if (n != 0 && cs != 0 && c / cs < n && r / cs < n) begin
        cx = c / cs;
        cy = r / cs;
        ox = c % cs;
        oy = r % cs;
        if (2 * margin < cs) begin
          lo = margin;
          hi = cs - 1 - margin;
          if (ox >= lo && ox <= hi && oy >= lo && oy <= hi) begin
            window_sums[cx] = (ox == lo && oy == lo) ? gray : window_sums[cx] + gray;
            if (ox == hi && oy == hi) begin
              last  = 1'b1;
              count = (hi - lo + 1) * (hi - lo + 1);
              if (window_sums[cx] < dark_limit * count) v.piece = PIECE_DARK;
              else if (window_sums[cx] > light_limit * count) v.piece = PIECE_LIGHT;
            end
          end
        end else begin
          last = (ox == cs - 1 && oy == cs - 1);
        end
        if (last) begin
          v.row  = cy[3:0];
          v.col  = cx[3:0];
          v.done = (cx == n - 1 && cy == n - 1);
          verdicts_q.insert(verdicts_q.size(), v);
        end
      end
      c++;
      if (c >= fs) begin
        c = 0;
        r++;
        if (r >= fs) r = 0;
      end
      col = c[9:0];
      row = r[9:0];
    endfunction

    function void note_failure(string text);
      failures++;
      if (failures <= 10) $display("%0t: %s", $time, text);
    endfunction

    function void check_verdict(logic [15:0] data, logic frame_done);
      verdict_t v;
      if (verdicts_q.size() == 0) begin
        note_failure($sformatf("unexpected cell result row %0d col %0d piece %0d done %0b",
                               data[3:0], data[7:4], data[9:8], frame_done));
        return;
      end
      v = verdicts_q.pop_front();
      if (data[3:0] !== v.row || data[7:4] !== v.col || data[9:8] !== v.piece ||
          frame_done !== v.done)
        note_failure($sformatf({"cell result mismatch: expected row %0d col %0d piece %0d ",
                                "done %0b, got row %0d col %0d piece %0d done %0b"},
                               v.row, v.col, v.piece, v.done,
                               data[3:0], data[7:4], data[9:8], frame_done));
    endfunction

    function int pending();
      return verdicts_q.size();
    endfunction

    function void drain_check();
      if (verdicts_q.size() != 0)
        note_failure($sformatf("%0d cell results never arrived", verdicts_q.size()));
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata  = '0;  // blue, green, red
  logic                 s_axis_tuser  = 1'b0;  // frame_start
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [15:0]          m_axis_tdata;  // cell_row, cell_col, piece, zero pad
  logic                 m_axis_tlast;  // frame_done
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [IDX_W-1:0]     cfg_index_i   = CFG_FRAME_SIDE;
  logic [CFG_W-1:0]     cfg_data_i    = '0;

  cell_verdict_board sb = new();

  texture_e    texture = TEX_NOISE;
  int          tone [16];
  int          flat_level = 0;
  int          burst_left = 0;
  int unsigned sent_items = 0;
  int unsigned spare_writes = 0;
  int unsigned quiet_cycles = 0;
  drain_e      pressure = DRAIN_FREE;
  int          pressure_left = 0;
  int          stall_run = 0;
  logic        stall_level = 1'b0;

  grid_cell_mean_classifier #(
    .MAX_CELLS(MAX_CELLS)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_verdict(m_axis_tdata, m_axis_tlast);
  end

  always @(posedge clk_i) begin
    if (pressure_left == 0) begin
      pressure      = drain_e'($urandom_range(0, 3));
      pressure_left = $urandom_range(50, 400);
    end
    pressure_left--;
    case (pressure)
      DRAIN_FREE: m_axis_tready <= 1'b1;
      DRAIN_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
      DRAIN_BURSTY: begin
        if (stall_run == 0) begin
          stall_level = !stall_level;
          stall_run   = $urandom_range(1, 20);
        end
        stall_run--;
        m_axis_tready <= stall_level;
      end
      default: m_axis_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("no item moved for %0d cycles", quiet_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [23:0] gray_pixel(logic [7:0] v);
    return {v, v, v};
  endfunction

  function automatic int near_limit(int dark, int light);
    int v;
    case ($urandom_range(0, 5))
      0: v = dark - 1;
      1: v = dark;
      2: v = light;
      3: v = light + 1;
      4: v = $urandom_range(0, 40);
      default: v = $urandom_range(215, 255);
    endcase
    return (v < 0) ? 0 : (v > 255) ? 255 : v;
  endfunction

  function automatic logic [23:0] make_pixel();
    int lvl;
    case (texture)
      TEX_NOISE: return 24'($urandom);
      TEX_GRAY:  lvl = $urandom_range(0, 255);
      TEX_TONES: lvl = tone[sb.col[5:2]] + int'($urandom_range(0, 2)) - 1;
      default:   lvl = flat_level;
    endcase
    lvl = (lvl < 0) ? 0 : (lvl > 255) ? 255 : lvl;
    return gray_pixel(8'(lvl));
  endfunction

  task automatic send_pixel(logic [23:0] bgr, logic start);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= bgr;
    s_axis_tuser  <= start;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_pixel(bgr[7:0], bgr[15:8], bgr[23:16], start);
    sent_items++;
  endtask

  task automatic drive_pixels(int pixels, bit fresh_frame);
    logic start;
    for (int i = 0; i < pixels; i++) begin
      if (i == 0) start = fresh_frame;
      else if (sb.col == 0 && sb.row == 0) start = ($urandom_range(0, 9) != 0);
      else start = ($urandom_range(0, 299) == 0);
      send_pixel(make_pixel(), start);
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [IDX_W-1:0] index, int unsigned value, int unsigned width);
    logic [CFG_W-1:0] data;
    data = CFG_W'(value);
    if (width < CFG_W && $urandom_range(0, 3) == 0) data |= CFG_W'($urandom) << width;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(index, data);
  endtask

  task automatic apply_config(int unsigned fs, n, cs, m, dark, light);
    settle();
    cfg_write(CFG_FRAME_SIDE, fs, FS_W);
    cfg_write(CFG_CELLS, n, 5);
    cfg_write(CFG_CELL_SIDE, cs, CS_W);
    cfg_write(CFG_MARGIN, m, 5);
    cfg_write(CFG_DARK_LIMIT, dark, GRAY_W);
    cfg_write(CFG_LIGHT_LIMIT, light, GRAY_W);
    if (spare_writes == 0 || $urandom_range(0, 7) == 0) begin
      spare_writes++;
      cfg_write(SPARE_REG_IDX, $urandom, CFG_W);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase();
    int unsigned cs, n, fs, m, dark, light, side, pixels;
    case ($urandom_range(0, 9))
      0: begin
        cs = 1;
        n  = MAX_CELLS;
      end
      1: begin
        cs = $urandom_range(0, 1) ? 0 : $urandom_range(64, 127);
        n  = $urandom_range(1, 2);
      end
      2: begin
        cs = $urandom_range(1, 3);
        n  = $urandom_range(0, 31);
      end
      3, 4: begin
        cs = $urandom_range(5, 8);
        n  = $urandom_range(1, 3);
      end
      default: begin
        cs = $urandom_range(1, 4);
        n  = $urandom_range(1, 4);
      end
    endcase
    case ($urandom_range(0, 7))
      0: fs = $urandom_range(0, 2047);
      1: fs = n * cs + $urandom_range(1, 3);
      2: fs = (n * cs > 3) ? n * cs - $urandom_range(1, 3) : n * cs;
      default: fs = n * cs;
    endcase
    case ($urandom_range(0, 5))
      0: m = $urandom_range(0, 31);
      1: m = (cs + 1) / 2;
      default: m = $urandom_range(0, cs / 4);
    endcase
    case ($urandom_range(0, 5))
      0: begin
        dark  = 0;
        light = 255;
      end
      1: begin
        dark  = 255;
        light = 0;
      end
      default: begin
        dark  = $urandom_range(0, 200);
        light = $urandom_range(dark, 255);
      end
    endcase
    apply_config(fs, n, cs, m, dark, light);
    texture    = texture_e'($urandom_range(0, 3));
    flat_level = near_limit(dark, light);
    foreach (tone[i]) tone[i] = near_limit(dark, light);
    side   = (fs == 0) ? 1 : (fs > FRAME_SIDE_MAX) ? FRAME_SIDE_MAX : fs;
    pixels = (side * side <= 300) ? side * side * $urandom_range(1, 2) + $urandom_range(0, 4)
                                  : $urandom_range(40, 160);
    if (pixels > RANDOM_ITEMS - sent_items) pixels = RANDOM_ITEMS - sent_items;
    drive_pixels(pixels, $urandom_range(0, 3) != 0);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_pixel(24'h000000, 1'b1);
    send_pixel(24'hffffff, 1'b0);
    send_pixel(24'h0000ff, 1'b0);
    send_pixel(24'h00ff00, 1'b0);
    send_pixel(24'hff0000, 1'b0);
    send_pixel(24'ha55a3c, 1'b0);

    apply_config(2, 2, 1, 0, 90, 230);
    send_pixel(gray_pixel(8'd0), 1'b1);
    send_pixel(gray_pixel(8'd255), 1'b0);
    send_pixel(gray_pixel(8'd90), 1'b0);
    send_pixel(gray_pixel(8'd230), 1'b0);

    texture = TEX_GRAY;
    apply_config(3, 1, 2, 1, 90, 230);
    drive_pixels(9, 1'b1);
    apply_config(0, 31, 127, 31, 255, 0);
    drive_pixels(2, 1'b1);
    apply_config(2047, 0, 1, 0, 0, 255);
    drive_pixels(2, 1'b1);
    apply_config(2, 1, 0, 0, 0, 255);
    drive_pixels(2, 1'b1);

    sent_items = 0;
    while (sent_items < RANDOM_ITEMS) random_phase();

    settle();
    sb.drain_check();
    if (sb.failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/gcmc_pkg.sv
rtl/gcmc_div.sv
rtl/gcmc_cell.sv
rtl/gcmc_front.sv
rtl/grid_cell_mean_classifier.sv
tb/sv/tb_grid_cell_mean_classifier.sv
